[rtl/tks_pkg.sv]
// tks_pkg: shared types and constants of the top-k score tracker
// payload structs of the request, result and limit channels, cell control struct
// no dependencies; compiled first
package tks_pkg;

    // field widths fixed by the channel formats
    localparam int unsigned SCORE_W = 32;
    localparam int unsigned ID_W    = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned KEY_W   = SCORE_W + ID_W;

    // flipping the id sign bit makes the signed tie-break an unsigned compare
    localparam logic [ID_W-1:0] ID_FLIP = {1'b1, {(ID_W-1){1'b0}}};

    // limit register value after reset
    localparam logic [CNT_W-1:0] K_LIMIT_RST = 7'd16;

    // request codes
    typedef enum logic {
        REQ_OFFER = 1'b0,
        REQ_DRAIN = 1'b1
    } t_req_code;

    typedef struct packed {
        t_req_code                req_type;
        logic [SCORE_W-1:0]       score;
        logic signed [ID_W-1:0]   item_id;
    } t_req;

    typedef struct packed {
        logic [SCORE_W-1:0]       entry_score;
        logic signed [ID_W-1:0]   entry_id;
        logic [CNT_W-1:0]         held_count;
        logic                     is_empty;
        logic                     last_entry;
    } t_res;

    typedef struct packed {
        logic [CNT_W-1:0]         k_limit;
    } t_cfg;

    // one held pair as it travels between neighbor cells
    typedef struct packed {
        logic                     vld;
        logic [KEY_W-1:0]         key;
    } t_slot;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;      // latch compare results against the offered key
        logic ins;      // insert offered key, upper part moves up one cell
        logic evict;    // drop cell 0, lower part moves down, insert offered key
        logic drain;    // whole chain moves down one cell
    } t_cell_ctl;

endpackage

[rtl/tks_chan_if.sv]
// tks_chan_if: valid/ready channel carrying one payload per transfer
// payload type given by parameter; used for request, result and limit channels
// no dependencies
interface tks_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tks_cell.sv]
// tks_cell: one slot of the sorted insertion chain
// holds one (score, id) key, compares it with an offered key and trades with neighbors
// depends on tks_pkg
module tks_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tks_pkg::t_cell_ctl  i_ctl,
    input  logic [63:0]         i_cmp_key,
    input  logic [63:0]         i_new_key,
    input  tks_pkg::t_slot      i_prev,
    input  logic                i_prev_lt,
    input  tks_pkg::t_slot      i_next,
    input  logic                i_next_lt,
    output tks_pkg::t_slot      o_slot,
    output logic                o_lt,
    output logic                o_eq
);
    import tks_pkg::*;

    logic             r_vld;
    logic             n_vld;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_lt;
    logic             n_lt;
    logic             r_eq;
    logic             n_eq;

    // slot update: keep, take the neighbor below or above, or take the new key
    always_comb begin
        n_vld = r_vld;
        n_key = r_key;
        if (i_ctl.ins) begin
            if (!i_prev_lt) begin
                n_vld = i_prev.vld;
                n_key = i_prev.key;
            end else if (!r_lt) begin
                n_vld = 1'b1;
                n_key = i_new_key;
            end
        end else if (i_ctl.evict) begin
            if (i_next_lt) begin
                n_vld = i_next.vld;
                n_key = i_next.key;
            end else if (r_lt) begin
                n_vld = 1'b1;
                n_key = i_new_key;
            end
        end else if (i_ctl.drain) begin
            n_vld = i_next.vld;
            n_key = i_next.key;
        end
    end

    // compare flags against the offered key, held until the next offer
    always_comb begin
        n_lt = r_lt;
        n_eq = r_eq;
        if (i_ctl.cmp) begin
            n_lt = r_vld && (r_key < i_cmp_key);
            n_eq = r_vld && (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
        end
    end

    // key payload, no reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_slot = '{vld: r_vld, key: r_key};
    assign o_lt   = r_lt;
    assign o_eq   = r_eq;

endmodule

[rtl/top_k_score_tracker.sv]
// top_k_score_tracker: keeps the k largest (score, id) pairs offered and drains them sorted
// sequencer, limit register, result register and a chain of tks_cell slots
// depends on tks_pkg, tks_chan_if, tks_cell
//
// Usage
//   i_req  : requests; req_type offer adds (score, item_id), drain empties the store.
//            A transfer is taken when valid and ready are high at a rising edge.
//   o_res  : drain results, ascending by score then signed id, last_entry on the final
//            one; a drain of an empty store gives one result with is_empty set.
//   i_cfg  : k_limit write, always ready; write it only while the block is idle.
// Operation
//   For an offer, the transfer cycle latches every cell's compare against the offered
//   key, and the next cycle inserts it with one shift across the cell chain. A drain
//   gives one result per held entry, one per cycle while the output is open, as cell 0
//   feeds the result register and the chain moves down; an empty drain gives its single
//   is_empty result. i_req.ready is low while an offer or a drain is in progress.
// Reset
//   Synchronous, active low: store empty, k_limit back to 16, no result pending.
// Stalls
//   The result register holds a pending result while o_res.ready is low; the drain waits
//   and no request is taken until it finishes.
module top_k_score_tracker #(
    parameter int unsigned K_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tks_chan_if.sink   i_req,
    tks_chan_if.source o_res,
    tks_chan_if.sink   i_cfg
);
    import tks_pkg::*;

    localparam int unsigned CW = $clog2(K_MAX + 1);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_INS   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_klim;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      n_held;
    logic [CW-1:0]      r_left;
    logic [CW-1:0]      n_left;
    logic [KEY_W-1:0]   r_key;
    logic               r_out_vld;
    logic               n_out_vld;
    t_res               r_out;
    t_res               n_out;

    logic               w_req_xfer;
    logic [KEY_W-1:0]   w_req_key;
    logic [CW-1:0]      w_lim;
    logic               w_dup;
    logic               w_full;
    logic               w_ign;
    logic               w_out_free;
    logic               w_fin;
    t_cell_ctl          w_ctl;
    t_slot              w_slot [K_MAX];
    logic [K_MAX-1:0]   w_lt;
    logic [K_MAX-1:0]   w_eq;

    // request and limit channel handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign w_req_key   = {i_req.payload.score, i_req.payload.item_id ^ ID_FLIP};

    // effective limit saturates at the chain length
    assign w_lim = (r_klim > CNT_W'(K_MAX)) ? CW'(K_MAX) : r_klim[CW-1:0];

    // offer decision from the latched compare flags
    assign w_dup  = |w_eq;
    assign w_full = (r_count == w_lim);
    assign w_ign  = (w_lim == '0) || (r_count > w_lim) || w_dup || (w_full && !w_lt[0]);

    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_fin      = (r_state == S_DRAIN) && w_out_free && ((r_held == '0) || (r_left == CW'(1)));

    // control broadcast to the chain
    always_comb begin
        w_ctl       = '0;
        w_ctl.cmp   = w_req_xfer && (i_req.payload.req_type == REQ_OFFER);
        w_ctl.ins   = (r_state == S_INS) && !w_ign && !w_full;
        w_ctl.evict = (r_state == S_INS) && !w_ign && w_full;
        w_ctl.drain = (r_state == S_DRAIN) && w_out_free && (r_held != '0);
    end

    // sequencer, counters and result register
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_held    = r_held;
        n_left    = r_left;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_res.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_xfer) begin
                    if (i_req.payload.req_type == REQ_OFFER) begin
                        n_state = S_INS;
                    end else begin
                        n_held  = r_count;
                        n_left  = r_count;
                        n_count = '0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_INS: begin
                if (w_ctl.ins) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    if (r_held == '0) begin
                        n_out = '{entry_score: '0, entry_id: '0, held_count: '0,
                                  is_empty: 1'b1, last_entry: 1'b1};
                    end else begin
                        n_out.entry_score = w_slot[0].key[KEY_W-1:ID_W];
                        n_out.entry_id    = signed'(w_slot[0].key[ID_W-1:0] ^ ID_FLIP);
                        n_out.held_count  = CNT_W'(r_held);
                        n_out.is_empty    = 1'b0;
                        n_out.last_entry  = (r_left == CW'(1));
                        n_left            = r_left - CW'(1);
                    end
                    if (w_fin) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_held    <= '0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
            r_klim    <= K_LIMIT_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_held    <= n_held;
            r_left    <= n_left;
            r_out_vld <= n_out_vld;
            if (i_cfg.valid && i_cfg.ready) begin
                r_klim <= i_cfg.payload.k_limit;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_ctl.cmp) begin
            r_key <= w_req_key;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.payload = r_out;

    // sorted chain, cell 0 holds the smallest pair
    for (genvar g = 0; g < K_MAX; g++) begin : g_cell
        t_slot w_prev;
        t_slot w_next;
        logic  w_prev_lt;
        logic  w_next_lt;

        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_lt = 1'b1;
        end else begin : g_mid_lo
            assign w_prev    = w_slot[g-1];
            assign w_prev_lt = w_lt[g-1];
        end

        if (g == K_MAX - 1) begin : g_last
            assign w_next    = '0;
            assign w_next_lt = 1'b0;
        end else begin : g_mid_hi
            assign w_next    = w_slot[g+1];
            assign w_next_lt = w_lt[g+1];
        end

        tks_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_cmp_key (w_req_key),
            .i_new_key (r_key),
            .i_prev    (w_prev),
            .i_prev_lt (w_prev_lt),
            .i_next    (w_next),
            .i_next_lt (w_next_lt),
            .o_slot    (w_slot[g]),
            .o_lt      (w_lt[g]),
            .o_eq      (w_eq[g])
        );
    end

    // held count never exceeds the chain length
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(K_MAX))
        else $error("held count above chain length");

    // a completed drain leaves the chain empty
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> !w_slot[0].vld)
        else $error("chain not empty after drain");

    // an empty-store result is always the last of its drain
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.is_empty |-> r_out.last_entry)
        else $error("empty result without last mark");

    // an insert without eviction grows the store by one and leaves cell 0 filled
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CW'(1)) && w_slot[0].vld)
        else $error("insert did not grow the store");

    // no request is taken while a drain is in progress
    a_drain_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !i_req.ready)
        else $error("request taken during drain");

endmodule

[verif/top_k_score_tracker_chk.sv]
// top_k_score_tracker_chk: watches the request, limit and result channels of the tracker
// keeps its own sorted store, predicts every drain and compares field by field
// depends on tks_pkg
`timescale 1ns / 100ps

module top_k_score_tracker_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  tks_pkg::t_req  i_req,
    input  logic           i_res_valid,
    input  logic           i_res_ready,
    input  tks_pkg::t_res  i_res,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  tks_pkg::t_cfg  i_cfg,
    output int unsigned    o_err_count,
    output int unsigned    o_pending
);
    import tks_pkg::*;

    localparam int unsigned STORE_DEPTH = 64;

    // held pairs as rank keys, ascending
    logic [KEY_W-1:0] held_keys[$];
    // drain entries not yet seen on the result channel
    t_res             due_results[$];
    logic [CNT_W-1:0] limit_reg = K_LIMIT_RST;
    int unsigned      err_total = 0;

    // score on top, id with flipped sign bit below: plain unsigned order
    function automatic logic [KEY_W-1:0] rank_key(logic [SCORE_W-1:0] s, logic [ID_W-1:0] id);
        return {s, ~id[ID_W-1], id[ID_W-2:0]};
    endfunction

    function automatic void offer_pair(logic [SCORE_W-1:0] s, logic [ID_W-1:0] id);
        int unsigned      lim;
        int unsigned      pos;
        logic [KEY_W-1:0] key;
        lim = (limit_reg > STORE_DEPTH) ? STORE_DEPTH : limit_reg;
        key = rank_key(s, id);
        if (lim == 0 || held_keys.size() > lim) return;
        foreach (held_keys[i]) begin
            if (held_keys[i] == key) return;
        end
        // full store: only a strictly larger pair pushes out the smallest
        if (held_keys.size() == lim) begin
            if (key <= held_keys[0]) return;
            void'(held_keys.pop_front());
        end
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key) pos++;
        held_keys.insert(pos, key);
    endfunction

    function automatic void drain_store();
        t_res        r;
        int unsigned n;
        n = held_keys.size();
        r = '0;
        // empty store still answers with one marked entry
        if (n == 0) begin
            r.is_empty   = 1'b1;
            r.last_entry = 1'b1;
            due_results.push_back(r);
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            r.entry_score = held_keys[i][KEY_W-1 -: SCORE_W];
            r.entry_id    = {~held_keys[i][ID_W-1], held_keys[i][ID_W-2:0]};
            r.held_count  = CNT_W'(n);
            r.is_empty    = 1'b0;
            r.last_entry  = (i == n - 1);
            due_results.push_back(r);
        end
        held_keys.delete();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_total++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    task automatic check_entry(t_res got);
        t_res want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing due", {got.entry_score, got.entry_id}, 64'h0);
            return;
        end
        want = due_results.pop_front();
        if (got.entry_score !== want.entry_score)
            report_mismatch("entry_score", 64'(got.entry_score), 64'(want.entry_score));
        if (got.entry_id !== want.entry_id)
            report_mismatch("entry_id", 64'(unsigned'(got.entry_id)),
                            64'(unsigned'(want.entry_id)));
        if (got.held_count !== want.held_count)
            report_mismatch("held_count", 64'(got.held_count), 64'(want.held_count));
        if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
        if (got.last_entry !== want.last_entry)
            report_mismatch("last_entry", 64'(got.last_entry), 64'(want.last_entry));
    endtask

    // sample every transfer at the edge it happens on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_keys.delete();
            due_results.delete();
            limit_reg = K_LIMIT_RST;
        end else begin
            if (i_res_valid && i_res_ready) check_entry(i_res);
            if (i_cfg_valid && i_cfg_ready) limit_reg = i_cfg.k_limit;
            if (i_req_valid && i_req_ready) begin
                if (i_req.req_type == REQ_DRAIN)
                    drain_store();
                else
                    offer_pair(i_req.score, i_req.item_id);
            end
        end
        o_err_count <= err_total;
        o_pending   <= unsigned'(due_results.size());
    end

endmodule

[verif/top_k_score_tracker_tb.sv]
// top_k_score_tracker_tb: clock, reset and stimulus for the top-k score tracker
// directed corner cases, then random phases under several limits with idling and stalls
// depends on tks_pkg, tks_chan_if, top_k_score_tracker, top_k_score_tracker_chk
`timescale 1ns / 100ps

module top_k_score_tracker_tb;
    import tks_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 350;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned IDLE_PCT     = 36;
    localparam int unsigned POOL_DEPTH   = 32;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned err_count;
    int unsigned pending_count;
    logic        calm_stretch = 1'b0;
    int unsigned hold_req     = 0;
    logic [63:0] pair_pool[$];

    tks_chan_if #(.T(t_req)) req_ch ();
    tks_chan_if #(.T(t_res)) res_ch ();
    tks_chan_if #(.T(t_cfg)) cfg_ch ();

    top_k_score_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    top_k_score_tracker_chk chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.payload),
        .i_res_valid (res_ch.valid),
        .i_res_ready (res_ch.ready),
        .i_res       (res_ch.payload),
        .i_cfg_valid (cfg_ch.valid),
        .i_cfg_ready (cfg_ch.ready),
        .i_cfg       (cfg_ch.payload),
        .o_err_count (err_count),
        .o_pending   (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        int unsigned hold_seen;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic push_request(t_req_code kind, logic [31:0] s, logic [31:0] id);
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= '{req_type: kind, score: s, item_id: id};
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic offer(logic [31:0] s, logic [31:0] id);
        push_request(REQ_OFFER, s, id);
    endtask

    // drain payload fields are don't-care, so toggle them too
    task automatic drain();
        push_request(REQ_DRAIN, $urandom, $urandom);
    endtask

    // stop offering and wait for every due entry plus the offer pipeline
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [CNT_W-1:0] v);
        settle();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= '{k_limit: v};
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // random pair: reuse of earlier pairs, tie-heavy values and full-range values
    task automatic random_offer();
        logic [31:0] s;
        logic [31:0] id;
        if (pair_pool.size() > 0 && $urandom_range(99) < 15) begin
            {s, id} = pair_pool[$urandom_range(pair_pool.size() - 1)];
        end else begin
            case ($urandom_range(3))
                0:       s = $urandom;
                1:       s = {8'($urandom_range(3)), 24'h0};
                2:       s = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                default: s = $urandom_range(7);
            endcase
            case ($urandom_range(2))
                0:       id = $urandom;
                1:       id = 32'($urandom_range(4)) - 32'd2;
                default: id = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            pair_pool.push_back({s, id});
            if (pair_pool.size() > POOL_DEPTH) void'(pair_pool.pop_front());
        end
        offer(s, id);
    endtask

    // stimulus and verdict
    initial begin
        int unsigned      sent;
        int unsigned      phase;
        int unsigned      n_items;
        logic [CNT_W-1:0] lim;

        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store after reset
        drain();

        // tiny limit: extremes, signed tie-break, eviction, duplicate, too-small offers
        set_limit(7'd3);
        offer(32'h0, 32'h8000_0000);
        offer(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        offer(32'h0500_0000, 32'hFFFF_FFFF);
        offer(32'h0500_0000, 32'h0000_0001);
        offer(32'h0500_0000, 32'h0000_0001);
        offer(32'h0500_0000, 32'hFFFF_FFFE);
        offer(32'h0, 32'h0);
        drain();

        // zero limit ignores every offer
        set_limit(7'd0);
        offer(32'h0000_007B, 32'h4);
        drain();

        // limit above the store depth saturates
        set_limit(7'd127);
        offer(32'h1234_5678, 32'h0);
        offer(32'h1234_5678, 32'h8000_0000);
        offer(32'h8000_0000, 32'h7FFF_FFFF);
        offer(32'h0000_0001, 32'hFFFF_FFFF);
        offer(32'hAAAA_AAAA, 32'h5555_5555);
        offer(32'h5555_5555, 32'hAAAA_AAAA);

        // limit dropped below the held count: offers ignored, store kept
        set_limit(7'd2);
        offer(32'hFFFF_FFFF, 32'h0);
        drain();

        set_limit(7'd64);
        offer(32'h0300_0000, 32'h3);
        offer(32'h0300_0000, 32'hFFFF_FFFD);
        offer(32'h0100_0000, 32'h0);
        drain();

        // random phases, each under its own limit
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            case ($urandom_range(7))
                0:       lim = 7'd0;
                1:       lim = 7'd1;
                2:       lim = 7'($urandom_range(2, 8));
                3:       lim = 7'($urandom_range(9, 63));
                4:       lim = 7'd64;
                5:       lim = 7'($urandom_range(65, 126));
                6:       lim = 7'd127;
                default: lim = K_LIMIT_RST;
            endcase
            if (phase == 2) lim = 7'd64;
            set_limit(lim);
            calm_stretch <= (phase == 3);

            if (phase == 2)
                n_items = 40;
            else if (phase == 3)
                n_items = 60;
            else if (lim >= 7'd64 && $urandom_range(1))
                n_items = $urandom_range(64, 90);
            else
                n_items = $urandom_range(2, 24);

            for (int unsigned i = 0; i < n_items; i++) begin
                if ($urandom_range(99) < 8) drain();
                else random_offer();
                sent++;
            end

            if (phase == 2) begin
                // results held back long while offers keep coming behind the drain
                hold_req <= hold_req + 1;
                drain();
                repeat (6) random_offer();
                drain();
                sent += 8;
            end else if ($urandom_range(99) < 80) begin
                drain();
                sent++;
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
